[src/rgbhsl_pkg.sv]
// shared types and constants of the rgb to hsl converter
`default_nettype none

package rgbhsl_pkg;

   localparam int unsigned CH_W      = 8;   // one color channel
   localparam int unsigned HUE_W     = 15;  // hue result port
   localparam int unsigned SAT_W     = 13;  // saturation result port
   localparam int unsigned LSUM_W    = 9;   // max plus min
   localparam int unsigned HNUM_W    = 17;  // hue numerator in degrees times diff, below 360 * 255
   localparam int unsigned HCALC_W   = HNUM_W + 1;
   localparam int unsigned HUE_INT_W = 9;   // whole degrees stay below 512

   localparam logic [HCALC_W-1:0] DEG_60  = HCALC_W'(60);
   localparam logic [HCALC_W-1:0] DEG_120 = HCALC_W'(120);
   localparam logic [HCALC_W-1:0] DEG_240 = HCALC_W'(240);
   localparam logic [HCALC_W-1:0] DEG_360 = HCALC_W'(360);

   localparam logic [LSUM_W-1:0] HALF_SUM = LSUM_W'(255);
   localparam logic [LSUM_W-1:0] FULL_SUM = LSUM_W'(510);

   // queue between front and back
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = 1;
   localparam int unsigned QCNT_W = 2;

   // classified pixel as it travels from front to back
   typedef struct packed {
      logic [HNUM_W-1:0] hue_num;
      logic [CH_W-1:0]   diff;
      logic [CH_W-1:0]   sat_den;
      logic [LSUM_W-1:0] lsum;
   } item_type;

endpackage

`default_nettype wire

[src/rgbhsl_front.sv]
// front part: takes a pixel, finds max, min and sector, forms numerators
`default_nettype none

module rgbhsl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rgbhsl_pkg::CH_W-1:0]   red,
   input  logic [rgbhsl_pkg::CH_W-1:0]   green,
   input  logic [rgbhsl_pkg::CH_W-1:0]   blue,
   input  logic                          q_full,
   output logic                          busy,
   output logic                          push,
   output rgbhsl_pkg::item_type          item
);

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   logic                        vld_ff, vld_in;
   logic [rgbhsl_pkg::CH_W-1:0] red_ff, green_ff, blue_ff;
   logic                        accept;

   sector_type                       sector;
   logic [rgbhsl_pkg::CH_W-1:0]      mx, mn, diff;
   logic [rgbhsl_pkg::LSUM_W-1:0]    sum;
   logic [rgbhsl_pkg::HCALC_W-1:0]   num_wide;

   assign busy   = vld_ff & q_full;
   assign accept = start & ~busy;
   assign push   = vld_ff & ~q_full;
   assign vld_in = accept | (vld_ff & q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         red_ff   <= red;
         green_ff <= green;
         blue_ff  <= blue;
      end
   end

   // red wins ties over green, green over blue
   always_comb begin
      priority if (red_ff >= green_ff && red_ff >= blue_ff) begin
         sector = SECT_RED;
         mx     = red_ff;
      end else if (green_ff >= blue_ff) begin
         sector = SECT_GREEN;
         mx     = green_ff;
      end else begin
         sector = SECT_BLUE;
         mx     = blue_ff;
      end
   end

   always_comb begin
      mn = red_ff;
      if (green_ff < mn) begin
         mn = green_ff;
      end
      if (blue_ff < mn) begin
         mn = blue_ff;
      end
   end

   assign diff = mx - mn;
   assign sum  = rgbhsl_pkg::LSUM_W'(mx) + rgbhsl_pkg::LSUM_W'(mn);

   // numerators never go negative since each channel difference is at most diff
   always_comb begin
      unique case (sector)
         SECT_RED: begin
            if (green_ff >= blue_ff) begin
               num_wide = rgbhsl_pkg::DEG_60 * rgbhsl_pkg::HCALC_W'(green_ff - blue_ff);
            end else begin
               num_wide = rgbhsl_pkg::DEG_360 * rgbhsl_pkg::HCALC_W'(diff)
                        - rgbhsl_pkg::DEG_60 * rgbhsl_pkg::HCALC_W'(blue_ff - green_ff);
            end
         end
         SECT_GREEN: begin
            num_wide = rgbhsl_pkg::DEG_120 * rgbhsl_pkg::HCALC_W'(diff)
                     + rgbhsl_pkg::DEG_60 * rgbhsl_pkg::HCALC_W'(blue_ff)
                     - rgbhsl_pkg::DEG_60 * rgbhsl_pkg::HCALC_W'(red_ff);
         end
         SECT_BLUE: begin
            num_wide = rgbhsl_pkg::DEG_240 * rgbhsl_pkg::HCALC_W'(diff)
                     + rgbhsl_pkg::DEG_60 * rgbhsl_pkg::HCALC_W'(red_ff)
                     - rgbhsl_pkg::DEG_60 * rgbhsl_pkg::HCALC_W'(green_ff);
         end
         default: begin
            num_wide = '0;
         end
      endcase
   end

   always_comb begin
      item.hue_num = rgbhsl_pkg::HNUM_W'(num_wide);
      item.diff    = diff;
      item.lsum    = sum;
      if (sum <= rgbhsl_pkg::HALF_SUM) begin
         item.sat_den = rgbhsl_pkg::CH_W'(sum);
      end else begin
         item.sat_den = rgbhsl_pkg::CH_W'(rgbhsl_pkg::FULL_SUM - sum);
      end
   end

`ifndef ASSERT_OFF
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && q_full) |=> vld_ff)
      else $error("front dropped an item while the queue was full");
`endif

endmodule

`default_nettype wire

[src/rgbhsl_queue.sv]
// short queue between front and back, drained whenever it holds an item
`default_nettype none

module rgbhsl_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rgbhsl_pkg::item_type item_in,
   output logic                 full,
   output logic                 out_vld,
   output rgbhsl_pkg::item_type item_out
);

   rgbhsl_pkg::item_type              mem_ff [rgbhsl_pkg::QDEPTH];
   logic [rgbhsl_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [rgbhsl_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                              pop;

   assign full     = (cnt_ff == rgbhsl_pkg::QCNT_W'(rgbhsl_pkg::QDEPTH));
   assign out_vld  = (cnt_ff != '0);
   assign pop      = out_vld;
   assign item_out = mem_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + rgbhsl_pkg::QCNT_W'(1);
         2'b01:   cnt_in = cnt_ff - rgbhsl_pkg::QCNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + rgbhsl_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + rgbhsl_pkg::QPTR_W'(1);
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= rgbhsl_pkg::QCNT_W'(rgbhsl_pkg::QDEPTH))
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
`endif

endmodule

`default_nettype wire

[src/rgbhsl_div.sv]
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module rgbhsl_div #(
   parameter int unsigned NUM_W  = 23,
   parameter int unsigned DEN_W  = 8,
   parameter int unsigned QUOT_W = 15,
   parameter int unsigned PAD    = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              out_vld,
   output logic [QUOT_W-1:0] quot
);

   // upper dividend bits are below den whenever the quotient fits QUOT_W bits
   localparam int unsigned STEP_W = DEN_W + QUOT_W;

   logic              vld_ff [QUOT_W];
   logic [DEN_W-1:0]  rem_ff [QUOT_W];
   logic [QUOT_W-1:0] rq_ff  [QUOT_W];
   logic [DEN_W-1:0]  den_ff [QUOT_W];
   logic [STEP_W-1:0] step_in [QUOT_W];
   logic [QUOT_W-1:0] last_q;

   // rq holds unused dividend bits at the top, quotient bits enter at the bottom
   function automatic logic [STEP_W-1:0] div_step(
      input logic [DEN_W-1:0]  rem,
      input logic [QUOT_W-1:0] rq,
      input logic [DEN_W-1:0]  dv
   );
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_n;
      trial = {rem, rq[QUOT_W-1]};
      ge    = (trial >= {1'b0, dv});
      if (ge) begin
         rem_n = DEN_W'(trial - {1'b0, dv});
      end else begin
         rem_n = trial[DEN_W-1:0];
      end
      return {rem_n, rq[QUOT_W-2:0], ge};
   endfunction

   always_comb begin
      step_in[0] = div_step(DEN_W'(num[NUM_W-1:QUOT_W]), num[QUOT_W-1:0], den);
      for (int i = 1; i < QUOT_W; i++) begin
         step_in[i] = div_step(rem_ff[i-1], rq_ff[i-1], den_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUOT_W; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < QUOT_W; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      den_ff[0] <= den;
      for (int i = 1; i < QUOT_W; i++) begin
         den_ff[i] <= den_ff[i-1];
      end
      for (int i = 0; i < QUOT_W; i++) begin
         rem_ff[i] <= step_in[i][STEP_W-1:QUOT_W];
         rq_ff[i]  <= step_in[i][QUOT_W-1:0];
      end
   end

   // zero divisor only comes with a zero result
   assign last_q = (den_ff[QUOT_W-1] == '0) ? '0 : rq_ff[QUOT_W-1];

   if (PAD > 0) begin : g_pad
      logic              pad_vld_ff [PAD];
      logic [QUOT_W-1:0] pad_q_ff   [PAD];

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int i = 0; i < PAD; i++) begin
               pad_vld_ff[i] <= 1'b0;
            end
         end else begin
            pad_vld_ff[0] <= vld_ff[QUOT_W-1];
            for (int i = 1; i < PAD; i++) begin
               pad_vld_ff[i] <= pad_vld_ff[i-1];
            end
         end
         pad_q_ff[0] <= last_q;
         for (int i = 1; i < PAD; i++) begin
            pad_q_ff[i] <= pad_q_ff[i-1];
         end
      end

      assign out_vld = pad_vld_ff[PAD-1];
      assign quot    = pad_q_ff[PAD-1];
   end else begin : g_nopad
      assign out_vld = vld_ff[QUOT_W-1];
      assign quot    = last_q;
   end

`ifndef ASSERT_OFF
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QUOT_W-1] && den_ff[QUOT_W-1] != '0) |-> (rem_ff[QUOT_W-1] < den_ff[QUOT_W-1]))
      else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

[src/rgbhsl_back.sv]
// back part: hue and saturation dividers, lightness delay, result register
`default_nettype none

module rgbhsl_back #(
   parameter int unsigned HUE_FRAC_BITS = 6,
   parameter int unsigned SAT_FRAC_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_vld,
   input  rgbhsl_pkg::item_type            item,
   output logic                            rsp_strobe,
   output logic [rgbhsl_pkg::HUE_W-1:0]    rsp_hue,
   output logic [rgbhsl_pkg::SAT_W-1:0]    rsp_saturation,
   output logic [rgbhsl_pkg::LSUM_W-1:0]   rsp_lightness_sum
);

   localparam int unsigned HQ_W = rgbhsl_pkg::HUE_INT_W + HUE_FRAC_BITS;
   localparam int unsigned HN_W = rgbhsl_pkg::HNUM_W + HUE_FRAC_BITS;
   localparam int unsigned SQ_W = SAT_FRAC_BITS + 1;  // saturation reaches 1.0
   localparam int unsigned SN_W = rgbhsl_pkg::CH_W + SAT_FRAC_BITS;
   localparam int unsigned LAT  = (HQ_W > SQ_W) ? HQ_W : SQ_W;

   logic [HN_W-1:0]                 hue_dvd;
   logic [SN_W-1:0]                 sat_dvd;
   logic                            hue_vld, sat_vld;
   logic [HQ_W-1:0]                 hue_q;
   logic [SQ_W-1:0]                 sat_q;
   logic [rgbhsl_pkg::LSUM_W-1:0]   lsum_ff [LAT];

   logic                            strobe_ff;
   logic [rgbhsl_pkg::HUE_W-1:0]    hue_ff;
   logic [rgbhsl_pkg::SAT_W-1:0]    sat_ff;
   logic [rgbhsl_pkg::LSUM_W-1:0]   lsum_out_ff;

   assign hue_dvd = HN_W'(item.hue_num) << HUE_FRAC_BITS;
   assign sat_dvd = SN_W'(item.diff) << SAT_FRAC_BITS;

   rgbhsl_div #(
      .NUM_W  (HN_W),
      .DEN_W  (rgbhsl_pkg::CH_W),
      .QUOT_W (HQ_W),
      .PAD    (LAT - HQ_W)
   ) u_hue_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (q_vld),
      .num     (hue_dvd),
      .den     (item.diff),
      .out_vld (hue_vld),
      .quot    (hue_q)
   );

   rgbhsl_div #(
      .NUM_W  (SN_W),
      .DEN_W  (rgbhsl_pkg::CH_W),
      .QUOT_W (SQ_W),
      .PAD    (LAT - SQ_W)
   ) u_sat_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (q_vld),
      .num     (sat_dvd),
      .den     (item.sat_den),
      .out_vld (sat_vld),
      .quot    (sat_q)
   );

   always_ff @(posedge clock) begin
      lsum_ff[0] <= item.lsum;
      for (int i = 1; i < LAT; i++) begin
         lsum_ff[i] <= lsum_ff[i-1];
      end
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= hue_vld;
      end
      hue_ff      <= rgbhsl_pkg::HUE_W'(hue_q);
      sat_ff      <= rgbhsl_pkg::SAT_W'(sat_q);
      lsum_out_ff <= lsum_ff[LAT-1];
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_hue           = hue_ff;
   assign rsp_saturation    = sat_ff;
   assign rsp_lightness_sum = lsum_out_ff;

`ifndef ASSERT_OFF
   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      hue_vld == sat_vld)
      else $error("hue and saturation dividers out of step");
`endif

endmodule

`default_nettype wire

[src/rgb_to_hsl_converter.sv]
// top level of the rgb to hsl converter
`default_nettype none

// Converts one 8-bit RGB pixel per item into hue, saturation and max+min.
// Input channel: req_red/req_green/req_blue are taken at a rising edge with
//   start high and busy low. busy rises only if the front register and the
//   queue behind it are both full, which does not happen in steady streaming,
//   so one item is accepted every clock.
// Result channel: rsp_strobe marks one cycle that carries rsp_hue (degrees
//   times 2^HUE_FRAC_BITS), rsp_saturation (times 2^SAT_FRAC_BITS) and
//   rsp_lightness_sum (max plus min, 0..510). The receiver cannot stall, so
//   results leave in order, one per accepted item, and are never held.
// Path: front register, queue, divider stages and result register lie
//   between the accepting edge and the strobe; the longer bit-per-stage
//   divider has max(HUE_FRAC_BITS + 9, SAT_FRAC_BITS + 1) stages.
// Throughput: one item per clock while not busy; dividers fully pipelined.
// Reset: synchronous, clears the front valid, the queue and all pipeline
//   valids; items in flight are dropped and no strobe follows.

module rgb_to_hsl_converter #(
   parameter int unsigned HUE_FRAC_BITS = 6,
   parameter int unsigned SAT_FRAC_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [rgbhsl_pkg::CH_W-1:0]     req_red,
   input  logic [rgbhsl_pkg::CH_W-1:0]     req_green,
   input  logic [rgbhsl_pkg::CH_W-1:0]     req_blue,
   output logic                            rsp_strobe,
   output logic [rgbhsl_pkg::HUE_W-1:0]    rsp_hue,
   output logic [rgbhsl_pkg::SAT_W-1:0]    rsp_saturation,
   output logic [rgbhsl_pkg::LSUM_W-1:0]   rsp_lightness_sum
);

   // front to queue
   logic                 push;
   logic                 q_full;
   rgbhsl_pkg::item_type front_item;

   // queue to back
   logic                 q_vld;
   rgbhsl_pkg::item_type back_item;

   // classify: max, min, sector, hue numerator and saturation divisor
   rgbhsl_front u_front (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .red    (req_red),
      .green  (req_green),
      .blue   (req_blue),
      .q_full (q_full),
      .busy   (busy),
      .push   (push),
      .item   (front_item)
   );

   // decouples the classifier from the divider pipeline
   rgbhsl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item_in  (front_item),
      .full     (q_full),
      .out_vld  (q_vld),
      .item_out (back_item)
   );

   // both divisions plus the registered result
   rgbhsl_back #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .SAT_FRAC_BITS (SAT_FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_vld             (q_vld),
      .item              (back_item),
      .rsp_strobe        (rsp_strobe),
      .rsp_hue           (rsp_hue),
      .rsp_saturation    (rsp_saturation),
      .rsp_lightness_sum (rsp_lightness_sum)
   );

endmodule

`default_nettype wire

[verif/rgb_to_hsl_checker.sv]
// result checker for the rgb to hsl converter: watches both channels, predicts and compares

module rgb_to_hsl_checker #(
   parameter int unsigned HUE_FRAC_BITS = 6,
   parameter int unsigned SAT_FRAC_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [rgbhsl_pkg::CH_W-1:0]       req_red,
   input  logic [rgbhsl_pkg::CH_W-1:0]       req_green,
   input  logic [rgbhsl_pkg::CH_W-1:0]       req_blue,
   input  logic                              rsp_strobe,
   input  logic [rgbhsl_pkg::HUE_W-1:0]      rsp_hue,
   input  logic [rgbhsl_pkg::SAT_W-1:0]      rsp_saturation,
   input  logic [rgbhsl_pkg::LSUM_W-1:0]     rsp_lightness_sum,
   output int unsigned                       pending_count,
   output int unsigned                       error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [rgbhsl_pkg::CH_W-1:0]   red;
      logic [rgbhsl_pkg::CH_W-1:0]   green;
      logic [rgbhsl_pkg::CH_W-1:0]   blue;
      logic [rgbhsl_pkg::HUE_W-1:0]  hue;
      logic [rgbhsl_pkg::SAT_W-1:0]  sat;
      logic [rgbhsl_pkg::LSUM_W-1:0] lsum;
   } hsl_type;

   hsl_type expected_hsl_q[$];

   // exact fixed point conversion with floor rounding
   function automatic hsl_type convert_pixel(input logic [rgbhsl_pkg::CH_W-1:0] r, g, b);
      longint unsigned rv, gv, bv, mx, mn, d, sum, num, den, hue_full, sat_full;
      hsl_type res;
      rv = r;
      gv = g;
      bv = b;
      mx = rv;
      mn = rv;
      if (gv > mx) mx = gv;
      if (bv > mx) mx = bv;
      if (gv < mn) mn = gv;
      if (bv < mn) mn = bv;
      d        = mx - mn;
      sum      = mx + mn;
      hue_full = 0;
      sat_full = 0;
      if (d != 0) begin
         // red wins ties, then green
         if (mx == rv) begin
            if (gv >= bv) num = 60 * (gv - bv);
            else          num = 360 * d - 60 * (bv - gv);
         end else if (mx == gv) begin
            num = 120 * d + 60 * bv - 60 * rv;
         end else begin
            num = 240 * d + 60 * rv - 60 * gv;
         end
         hue_full = (num << HUE_FRAC_BITS) / d;
         den = (sum <= 255) ? sum : (510 - sum);
         if (den != 0) sat_full = (d << SAT_FRAC_BITS) / den;
      end
      res.red   = r;
      res.green = g;
      res.blue  = b;
      res.hue   = hue_full[rgbhsl_pkg::HUE_W-1:0];
      res.sat   = sat_full[rgbhsl_pkg::SAT_W-1:0];
      res.lsum  = sum[rgbhsl_pkg::LSUM_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      hsl_type want;
      if (reset) begin
         expected_hsl_q.delete();
         error_count = 0;
         pending_count <= 0;
      end else begin
         // retire before taking the new item, so a stray strobe never meets it
         if (rsp_strobe) begin
            if (expected_hsl_q.size() == 0) begin
               $error("result with no item outstanding: hue %0d saturation %0d lightness_sum %0d",
                      rsp_hue, rsp_saturation, rsp_lightness_sum);
               error_count++;
            end else begin
               want = expected_hsl_q.pop_front();
               if (rsp_hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d (rgb %0d %0d %0d)",
                         want.hue, rsp_hue, want.red, want.green, want.blue);
                  error_count++;
               end
               if (rsp_saturation !== want.sat) begin
                  $error("saturation: expected %0d, got %0d (rgb %0d %0d %0d)",
                         want.sat, rsp_saturation, want.red, want.green, want.blue);
                  error_count++;
               end
               if (rsp_lightness_sum !== want.lsum) begin
                  $error("lightness_sum: expected %0d, got %0d (rgb %0d %0d %0d)",
                         want.lsum, rsp_lightness_sum, want.red, want.green, want.blue);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            expected_hsl_q.push_back(convert_pixel(req_red, req_green, req_blue));
         pending_count <= expected_hsl_q.size();
      end
   end

endmodule

[verif/rgb_to_hsl_converter_tb.sv]
// testbench top of the rgb to hsl converter: clock, reset, pixel stimulus and verdict

module rgb_to_hsl_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HUE_FB       = 6;
   localparam int unsigned SAT_FB       = 12;
   localparam int unsigned RANDOM_ITEMS = 1500;
   localparam int unsigned SETTLE_CYCLES = 64;     // well past the depth of the pipeline
   localparam int unsigned CYCLE_LIMIT  = 300000;  // far above what the slowest run needs

   // hand-picked pixels, packed as red, green, blue
   localparam int unsigned N_DIRECTED = 22;
   localparam logic [3*rgbhsl_pkg::CH_W-1:0] DIRECTED_PIXELS [N_DIRECTED] = '{
      24'h000000,  // black
      24'hFFFFFF,  // white
      24'h808080,  // mid grey
      24'hFF0000,  // pure red
      24'h00FF00,  // pure green
      24'h0000FF,  // pure blue
      24'hFFFF00,  // red and green tie for max
      24'h00FFFF,  // green and blue tie for max
      24'hFF00FF,  // red and blue tie for max
      24'hFF0001,  // red max with green below blue, wraps just under 360
      24'hFF0100,
      24'hC80A64,  // red max, wrap case deep in the sector
      24'h0AC864,
      24'h640AC8,
      24'h010000,  // smallest nonzero pixel
      24'h807F7F,  // sum exactly half
      24'h817F7F,  // sum just above half
      24'hFFFEFE,  // near white
      24'hFEFF00,
      24'h0001FF,
      24'hAA5500,
      24'h55AAFF
   };

   typedef enum int unsigned {
      PIX_ANY,
      PIX_GREY,
      PIX_TIE,
      PIX_HALF,
      PIX_EXTREME,
      PIX_WRAP
   } pixel_kind_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [rgbhsl_pkg::CH_W-1:0]       req_red;
   logic [rgbhsl_pkg::CH_W-1:0]       req_green;
   logic [rgbhsl_pkg::CH_W-1:0]       req_blue;
   logic                              rsp_strobe;
   logic [rgbhsl_pkg::HUE_W-1:0]      rsp_hue;
   logic [rgbhsl_pkg::SAT_W-1:0]      rsp_saturation;
   logic [rgbhsl_pkg::LSUM_W-1:0]     rsp_lightness_sum;
   int unsigned                       pending_count;
   int unsigned                       error_count;
   int unsigned                       cycle_count = 0;
   bit                                burst_mode;

   rgb_to_hsl_converter #(
      .HUE_FRAC_BITS(HUE_FB),
      .SAT_FRAC_BITS(SAT_FB)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_strobe        (rsp_strobe),
      .rsp_hue           (rsp_hue),
      .rsp_saturation    (rsp_saturation),
      .rsp_lightness_sum (rsp_lightness_sum)
   );

   // prediction and comparison live beside the block
   rgb_to_hsl_checker #(
      .HUE_FRAC_BITS(HUE_FB),
      .SAT_FRAC_BITS(SAT_FB)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_strobe        (rsp_strobe),
      .rsp_hue           (rsp_hue),
      .rsp_saturation    (rsp_saturation),
      .rsp_lightness_sum (rsp_lightness_sum),
      .pending_count     (pending_count),
      .error_count       (error_count)
   );

   // 20 ns period
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case results never arrive
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rgb_to_hsl_converter: mismatch");
         $finish;
      end
   end

   // offer one pixel, hold it until taken, then maybe idle for a while
   // start is only lowered when a gap follows, so back-to-back items keep it high
   task automatic push_pixel(input logic [3*rgbhsl_pkg::CH_W-1:0] pix);
      int unsigned gap;
      start     <= 1'b1;
      req_red   <= pix[23:16];
      req_green <= pix[15:8];
      req_blue  <= pix[7:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = burst_mode ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let every outstanding result come back
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // random pixel shaped to hit ties, greys, channel extremes, the half-sum boundary and the hue wrap
   function automatic logic [3*rgbhsl_pkg::CH_W-1:0] make_pixel(input pixel_kind_type kind);
      logic [rgbhsl_pkg::CH_W-1:0] hi, mid, lo, r, g, b;
      logic [3*rgbhsl_pkg::CH_W-1:0] pix;
      int unsigned pick;
      pix = (3*rgbhsl_pkg::CH_W)'($urandom());
      case (kind)
         PIX_GREY: begin
            hi  = rgbhsl_pkg::CH_W'($urandom_range(0, 255));
            pix = {hi, hi, hi};
         end
         PIX_TIE: begin
            hi = rgbhsl_pkg::CH_W'($urandom_range(0, 255));
            lo = rgbhsl_pkg::CH_W'($urandom_range(0, hi));
            case ($urandom_range(0, 2))
               0:       pix = {hi, hi, lo};
               1:       pix = {lo, hi, hi};
               default: pix = {hi, lo, hi};
            endcase
         end
         PIX_HALF: begin
            // max + min lands on 255 or 256
            hi  = rgbhsl_pkg::CH_W'($urandom_range(128, 255));
            lo  = 8'(255 - hi + $urandom_range(0, 1));
            mid = rgbhsl_pkg::CH_W'($urandom_range(lo, hi));
            case ($urandom_range(0, 5))
               0:       pix = {hi, mid, lo};
               1:       pix = {hi, lo, mid};
               2:       pix = {mid, hi, lo};
               3:       pix = {lo, hi, mid};
               4:       pix = {mid, lo, hi};
               default: pix = {lo, mid, hi};
            endcase
         end
         PIX_EXTREME: begin
            for (int i = 0; i < 3; i++) begin
               pick = $urandom_range(0, 3);
               case (pick)
                  0:       hi = 8'd0;
                  1:       hi = 8'd1;
                  2:       hi = 8'd254;
                  default: hi = 8'd255;
               endcase
               pix[i*rgbhsl_pkg::CH_W +: rgbhsl_pkg::CH_W] = hi;
            end
         end
         PIX_WRAP: begin
            // red max, green strictly below blue
            r   = rgbhsl_pkg::CH_W'($urandom_range(1, 255));
            g   = rgbhsl_pkg::CH_W'($urandom_range(0, r - 1));
            b   = rgbhsl_pkg::CH_W'($urandom_range(g + 1, r));
            pix = {r, g, b};
         end
         default: ;
      endcase
      return pix;
   endfunction

   initial begin
      int unsigned sel;
      pixel_kind_type kind;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_red    <= '0;
      req_green  <= '0;
      req_blue   <= '0;
      burst_mode = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed corners, first streamed back to back
      burst_mode = 1'b1;
      for (int i = 0; i < N_DIRECTED; i++) push_pixel(DIRECTED_PIXELS[i]);
      wait_for_drain();

      // random pixels, switching between bursts and gappy stretches
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         // sender holds off once mid-run until the pipeline is empty
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         sel  = $urandom_range(0, 8);
         kind = (sel < 4) ? PIX_ANY : pixel_kind_type'(sel - 3);
         push_pixel(make_pixel(kind));
      end

      wait_for_drain();
      // catch any late stray strobe
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("rgb_to_hsl_converter: match");
      else
         $display("rgb_to_hsl_converter: mismatch");
      $finish;
   end

endmodule
